>>> sv/lgam_pkg.sv
// Shared types, register codes and table generators for the levels/gamma block.
// No dependencies; imported by lgam_lane and levels_gamma_adjust_top.
package lgam_pkg;

  localparam int LOG_TABLE_BITS_DEF = 8;
  localparam int NUM_LANES = 3;
  localparam int DIV_STAGES = 4;
  localparam int DIV_BITS = 4;
  // Input register, divider stages and nine power/mapping stages.
  localparam int LANE_DEPTH = 1 + DIV_STAGES + 9;

  typedef enum logic [2:0] {
    REG_IN_BLACK      = 3'd0,
    REG_IN_WHITE      = 3'd1,
    REG_INVERSE_GAMMA = 3'd2,
    REG_OUT_BLACK     = 3'd3,
    REG_OUT_WHITE     = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [7:0]  lvl_black;
    logic [7:0]  lvl_white;
    logic [15:0] inverse_gamma;
    logic [7:0]  ramp_black;
    logic [7:0]  ramp_white;
  } cfg_t;

  // Truncated log2 of a Q1.30 value in [1,2], result in Q1.16.
  function automatic logic [16:0] lgf(input logic [63:0] y_in);
    logic [63:0] y;
    logic [16:0] r;
    y = y_in;
    r = '0;
    if (y >= 64'h8000_0000) begin
      return 17'd65536;
    end
    for (int k = 0; k < 16; k++) begin
      y = (y * y) >> 30;
      r = {r[15:0], 1'b0};
      if (y >= 64'h8000_0000) begin
        r[0] = 1'b1;
        y = y >> 1;
      end
    end
    return r;
  endfunction

  function automatic logic [16:0] lt_val(input int i, input int l);
    logic [63:0] y;
    y = (64'(1 << l) + 64'(i)) << (30 - l);
    return lgf(y);
  endfunction

  // Smallest Q2.16 value whose log reaches i/2^l.
  function automatic logic [17:0] ex_val(input int i, input int l);
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] mid;
    logic [31:0] target;
    lo = 32'd65536;
    hi = 32'd131072;
    target = 32'(i) << (16 - l);
    for (int it = 0; it < 20; it++) begin
      if (lo < hi) begin
        mid = (lo + hi) >> 1;
        if (32'(lgf(64'(mid) << 14)) >= target) begin
          hi = mid;
        end else begin
          lo = mid + 32'd1;
        end
      end
    end
    return lo[17:0];
  endfunction

endpackage

>>> sv/lgam_lane.sv
// One color lane: normalization by a pipelined long divider, table-based power,
// and output ramp mapping. Depends on lgam_pkg.
module lgam_lane
  import lgam_pkg::*;
#(
  parameter int LOG_TABLE_BITS = LOG_TABLE_BITS_DEF
) (
  input  logic       clk,
  input  logic       en,
  input  cfg_t       cfg,
  input  logic [7:0] level_in,
  output logic [7:0] level_out
);

  localparam int S  = 1 << LOG_TABLE_BITS;
  localparam int LB = 15 - LOG_TABLE_BITS;
  localparam int GB = 16 - LOG_TABLE_BITS;
  localparam int QW = DIV_STAGES * DIV_BITS;

  logic [16:0] lt_rom [S+1];
  logic [17:0] ex_rom [S+1];

  for (genvar gi = 0; gi <= S; gi++) begin : g_rom
    localparam logic [16:0] LTV = lt_val(gi, LOG_TABLE_BITS);
    localparam logic [17:0] EXV = ex_val(gi, LOG_TABLE_BITS);
    assign lt_rom[gi] = LTV;
    assign ex_rom[gi] = EXV;
  end

  // Effective white point and divisor; user must keep these stable while items are in flight (unenforced).
  logic [8:0] iw;
  logic [8:0] den;
  assign iw  = (cfg.lvl_white > cfg.lvl_black) ? {1'b0, cfg.lvl_white}
                                               : {1'b0, cfg.lvl_black} + 9'd1;
  assign den = iw - {1'b0, cfg.lvl_black};

  // Stage 0: offset and clamp flags.
  logic [8:0] rem  [DIV_STAGES+1];
  logic [QW-1:0] quo [DIV_STAGES+1];
  logic       zf   [DIV_STAGES+1];
  logic       ff   [DIV_STAGES+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= {1'b0, level_in - cfg.lvl_black};
      quo[0] <= '0;
      zf[0]  <= (level_in <= cfg.lvl_black);
      ff[0]  <= ({1'b0, level_in} >= iw);
    end
  end

  // Long division, DIV_BITS quotient bits per stage.
  for (genvar gs = 0; gs < DIV_STAGES; gs++) begin : g_div
    logic [8:0]    rem_next;
    logic [QW-1:0] quo_next;
    always_comb begin
      logic [9:0] r2;
      rem_next = rem[gs];
      quo_next = quo[gs];
      for (int k = 0; k < DIV_BITS; k++) begin
        r2 = {rem_next, 1'b0};
        quo_next = {quo_next[QW-2:0], 1'b0};
        if (r2 >= {1'b0, den}) begin
          r2 = r2 - {1'b0, den};
          quo_next[0] = 1'b1;
        end
        rem_next = r2[8:0];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[gs+1] <= rem_next;
        quo[gs+1] <= quo_next;
        zf[gs+1]  <= zf[gs];
        ff[gs+1]  <= ff[gs];
      end
    end
  end

  // P1: leading one and mantissa split.
  logic [3:0]  lead;
  logic [15:0] nrm;
  always_comb begin
    lead = '0;
    for (int k = 0; k < 16; k++) begin
      if (quo[DIV_STAGES][k]) begin
        lead = 4'(k);
      end
    end
    nrm = quo[DIV_STAGES] << (4'd15 - lead);
  end

  // The clamp flags follow the data from P1 to P6.
  logic [LOG_TABLE_BITS-1:0] p1_a;
  logic [LB-1:0] p1_b;
  logic [3:0]    p1_p;
  logic [5:0]    p_zf;
  logic [5:0]    p_ff;
  always_ff @(posedge clk) begin
    if (en) begin
      p1_a    <= nrm[14:LB];
      p1_b    <= nrm[LB-1:0];
      p1_p    <= lead;
      p_zf[0] <= zf[DIV_STAGES];
      p_ff[0] <= ff[DIV_STAGES];
      for (int k = 1; k < 6; k++) begin
        p_zf[k] <= p_zf[k-1];
        p_ff[k] <= p_ff[k-1];
      end
    end
  end

  // P2: log table lookup.
  logic [LOG_TABLE_BITS:0] lt_ix;
  logic [16:0] p2_lo;
  logic [16:0] p2_diff;
  logic [LB-1:0] p2_b;
  logic [3:0]  p2_p;
  assign lt_ix = {1'b0, p1_a};
  always_ff @(posedge clk) begin
    if (en) begin
      p2_lo   <= lt_rom[lt_ix];
      p2_diff <= lt_rom[lt_ix + 1'b1] - lt_rom[lt_ix];
      p2_b    <= p1_b;
      p2_p    <= p1_p;
    end
  end

  // P3: interpolate log, form negated log in Q5.16.
  logic [16+LB:0] lprod;
  logic [16:0]    lf;
  logic [20:0]    p3_neg;
  assign lprod = p2_diff * p2_b;
  assign lf    = p2_lo + 17'(lprod >> LB);
  always_ff @(posedge clk) begin
    if (en) begin
      p3_neg <= {5'd16 - {1'b0, p2_p}, 16'd0} - {4'd0, lf};
    end
  end

  // P4: scale by the exponent.
  logic [36:0] gprod;
  logic [24:0] p4_t;
  assign gprod = p3_neg * cfg.inverse_gamma;
  always_ff @(posedge clk) begin
    if (en) begin
      p4_t <= gprod[36:12];
    end
  end

  // P5: exp table lookup on the fractional part.
  logic [16:0] g;
  logic [LOG_TABLE_BITS:0] ex_ix;
  logic [LOG_TABLE_BITS:0] ex_ix_hi;
  logic [17:0] p5_lo;
  logic [17:0] p5_diff;
  logic [GB-1:0] p5_b;
  logic [8:0]  p5_n;
  assign g        = 17'h10000 - {1'b0, p4_t[15:0]};
  assign ex_ix    = g[16:GB];
  assign ex_ix_hi = (ex_ix == (LOG_TABLE_BITS+1)'(S)) ? ex_ix : ex_ix + 1'b1;
  always_ff @(posedge clk) begin
    if (en) begin
      p5_lo   <= ex_rom[ex_ix];
      p5_diff <= ex_rom[ex_ix_hi] - ex_rom[ex_ix];
      p5_b    <= g[GB-1:0];
      p5_n    <= p4_t[24:16];
    end
  end

  // P6: interpolate exp.
  logic [17+GB:0] eprod;
  logic [17:0] p6_e;
  logic [8:0]  p6_n;
  assign eprod = p5_diff * p5_b;
  always_ff @(posedge clk) begin
    if (en) begin
      p6_e <= p5_lo + 18'(eprod >> GB);
      p6_n <= p5_n;
    end
  end

  // P7: integer part of the exponent becomes a right shift; end points override.
  logic [16:0] r_next;
  logic [16:0] p7_r;
  always_comb begin
    if (p_zf[5]) begin
      r_next = '0;
    end else if (p_ff[5]) begin
      r_next = 17'h10000;
    end else if (p6_n >= 9'd17) begin
      r_next = '0;
    end else begin
      r_next = 17'(p6_e >> (p6_n + 9'd1));
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      p7_r <= r_next;
    end
  end

  // P8: weights of both output end points.
  logic [24:0] p8_b;
  logic [24:0] p8_w;
  always_ff @(posedge clk) begin
    if (en) begin
      p8_b <= cfg.ramp_black * (17'h10000 - p7_r);
      p8_w <= cfg.ramp_white * p7_r;
    end
  end

  // P9: round half up and clamp.
  logic [25:0] sum;
  logic [9:0]  rnd;
  assign sum = {1'b0, p8_b} + {1'b0, p8_w} + 26'd32768;
  assign rnd = sum[25:16];
  always_ff @(posedge clk) begin
    if (en) begin
      level_out <= (rnd > 10'd255) ? 8'd255 : rnd[7:0];
    end
  end

endmodule

>>> sv/levels_gamma_adjust_top.sv
// Top level of the levels/gamma adjust block: config registers, pipeline control
// and three color lanes. Depends on lgam_pkg and lgam_lane.
//
// Usage: pixels enter on the s_axis channel, one transfer per pixel, with
// red, green and blue in the low, middle and high byte of s_axis_tdata.
// Adjusted pixels leave on m_axis in the same byte order. Every input
// transfer gives exactly one output transfer, in order.
// The block sustains one pixel per clock while the receiver keeps up; the
// three channels run in parallel lanes, each with a four-stage divider and a
// nine-stage power and mapping pipeline that advance together.
// The whole pipeline advances whenever the output register is empty or is
// being taken, so a stalled receiver holds the result and freezes all stages;
// bubbles inside the pipeline are not squeezed out during such a stall.
// Configuration is written through cfg_we/cfg_index/cfg_data while no pixel
// is in flight; writes take effect at the next clock edge.
// Synchronous reset clears all valid flags and restores the default levels
// (black 0, white 255, exponent 1.0) in both ramps.
module levels_gamma_adjust_top
  import lgam_pkg::*;
#(
  parameter int LOG_TABLE_BITS = LOG_TABLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red_in, green_in, blue_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // red_out, green_out, blue_out
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lvl_black     <= 8'd0;
      cfg.lvl_white     <= 8'd255;
      cfg.inverse_gamma <= 16'd4096;
      cfg.ramp_black    <= 8'd0;
      cfg.ramp_white    <= 8'd255;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_IN_BLACK:      cfg.lvl_black     <= cfg_data[7:0];
        REG_IN_WHITE:      cfg.lvl_white     <= cfg_data[7:0];
        REG_INVERSE_GAMMA: cfg.inverse_gamma <= cfg_data;
        REG_OUT_BLACK:     cfg.ramp_black    <= cfg_data[7:0];
        REG_OUT_WHITE:     cfg.ramp_white    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // One valid flag per pipeline stage; the last one qualifies the lane outputs.
  logic [LANE_DEPTH-1:0] vld;
  logic en;

  assign en            = !vld[LANE_DEPTH-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[LANE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LANE_DEPTH-2:0], s_axis_tvalid};
    end
  end

  // The merge is the packing of the three lane results into one transfer.
  for (genvar gl = 0; gl < NUM_LANES; gl++) begin : g_lane
    lgam_lane #(
      .LOG_TABLE_BITS(LOG_TABLE_BITS)
    ) u_lane (
      .clk      (clk),
      .en       (en),
      .cfg      (cfg),
      .level_in (s_axis_tdata[8*gl +: 8]),
      .level_out(m_axis_tdata[8*gl +: 8])
    );
  end

endmodule

>>> sv/lgam_chk.sv
// Port-level checker for levels_gamma_adjust_top, bound to every instance.
// Depends only on the top level's ports.
module lgam_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  // Reset empties the pipeline.
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // An empty output register never blocks the input side.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // A stalled output holds the whole pipeline, including the input.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken during output stall");

  // A stalled result keeps its data.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled output changed");

endmodule

bind levels_gamma_adjust_top lgam_chk u_lgam_chk (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
